// File: rtl/tpr_pkg.sv
// Shared types and constants for the tachometer period-to-rpm converter.
// No dependencies; imported by tacho_period_to_rpm and its testbench.
package tpr_pkg;

    // Microseconds in one minute; the dividend of every conversion
    localparam int unsigned USEC_PER_MIN = 60000000;

    // Dividend and quotient width (60000000 needs 26 bits)
    localparam int DIVIDEND_W = 26;
    // Pulses-per-revolution register width
    localparam int PPR_W      = 4;
    // Divisor is a clipped period (at most 60000000) times pulses per rev
    localparam int DIVISOR_W  = DIVIDEND_W + PPR_W;
    // Input period field width
    localparam int PERIOD_W   = 32;
    // Output rpm width and max_rpm register width
    localparam int RPM_W      = 16;
    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    // Divide step counter
    localparam int CNT_W      = $clog2(DIVIDEND_W);

    localparam logic [DIVIDEND_W-1:0] DIVIDEND = DIVIDEND_W'(USEC_PER_MIN);

    // Capture status codes
    typedef enum logic [1:0] {
        STATUS_CAPTURED = 2'd0,
        STATUS_TIMEOUT  = 2'd1,
        STATUS_FAILED   = 2'd2,
        STATUS_RSVD     = 2'd3
    } capture_status_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_COUNT = 1'd0,
        CFG_MAX_RPM     = 1'd1
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } tpr_state_t;

endpackage

// File: rtl/tacho_period_to_rpm.sv
// Fan tachometer period-to-rpm converter: one shared restoring divider step
// under a small sequencer. Depends on tpr_pkg.
//
// Each input beat carries one tachometer capture: a status on s_tuser and a
// period in microseconds on s_tdata. A captured period yields
// rpm = floor(60000000 / (period * pulse_count)); a zero period or one
// above 60000000 yields 0. A reading above max_rpm is a glitch and repeats
// the last valid rpm with m_tuser set; otherwise the reading is reported and
// becomes the last valid rpm. A timeout reports 0 and keeps the stored rpm.
// A failed capture (status 2 or 3) produces no output beat. A captured
// period in range is accepted, forms the divisor in the small multiplier,
// runs the 26 steps of the one-bit-per-cycle restoring divider and then
// has its limit checked before the output register. Timeouts and zero or
// out-of-range periods skip the multiplier and divider. s_tready is high only
// while the sequencer is idle; a finished result waits in the output
// register, so the next beat can be accepted while it is still pending.
module tacho_period_to_rpm
    import tpr_pkg::*;
#(
    parameter int PERIOD_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input beat
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PERIOD_W-1:0]   s_tdata,    // [31:0] period_us
    input  logic [1:0]            s_tuser,    // [1:0] capture_status
    // Output beat
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [RPM_W-1:0]      m_tdata,    // [15:0] rpm
    output logic                  m_tuser,    // [0] glitch_held
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Only the low PERIOD_WIDTH bits of the period are significant
    localparam logic [PERIOD_W-1:0] PERIOD_MASK = (PERIOD_WIDTH >= PERIOD_W) ?
        {PERIOD_W{1'b1}} : PERIOD_W'((64'd1 << PERIOD_WIDTH) - 64'd1);

    tpr_state_t              state_reg, state_next;

    logic [PPR_W-1:0]        ppr_reg;
    logic [RPM_W-1:0]        max_rpm_reg;
    logic [RPM_W-1:0]        last_rpm_reg;

    logic [DIVIDEND_W-1:0]   period_reg;
    logic [DIVISOR_W-1:0]    div_reg;
    logic [DIVISOR_W-1:0]    rem_reg;
    logic [DIVIDEND_W-1:0]   quo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    timeout_reg;

    logic                    out_valid_reg;
    logic [RPM_W-1:0]        out_rpm_reg;
    logic                    out_glitch_reg;

    logic                    in_beat;
    logic                    out_free;
    logic [PERIOD_W-1:0]     period_in;
    logic                    period_zero_path;
    capture_status_t         status_in;
    logic [PPR_W-1:0]        mult;
    logic [DIVISOR_W:0]      rem_shift;
    logic [DIVISOR_W+1:0]    trial;
    logic                    fits;
    logic                    glitch;

    assign status_in        = capture_status_t'(s_tuser);
    assign period_in        = s_tdata & PERIOD_MASK;
    assign period_zero_path = (period_in == '0) || (period_in > PERIOD_W'(USEC_PER_MIN));
    assign in_beat          = s_tvalid && s_tready;
    assign out_free         = !out_valid_reg || m_tready;
    assign mult             = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;

    // Shared divider step: shift in the next dividend bit, trial subtract
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, div_reg};
    assign fits      = !trial[DIVISOR_W+1];

    // Limit check on the finished quotient
    assign glitch = !timeout_reg && (quo_reg > DIVIDEND_W'(max_rpm_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    priority if (status_in == STATUS_TIMEOUT)
                        state_next = ST_DONE;
                    else if (status_in == STATUS_CAPTURED)
                        state_next = period_zero_path ? ST_DONE : ST_MULT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_MULT:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = out_valid_reg;
        m_tdata  = out_rpm_reg;
        m_tuser  = out_glitch_reg;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg     <= PPR_W'(2);
            max_rpm_reg <= RPM_W'(20000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PULSE_COUNT: ppr_reg     <= cfg_data[PPR_W-1:0];
                CFG_MAX_RPM:     max_rpm_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Divider datapath: load on accept, form divisor, then one bit a cycle
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    period_reg  <= period_in[DIVIDEND_W-1:0];
                    rem_reg     <= '0;
                    cnt_reg     <= CNT_W'(DIVIDEND_W - 1);
                    timeout_reg <= (status_in == STATUS_TIMEOUT);
                    quo_reg     <= (status_in == STATUS_CAPTURED && !period_zero_path) ?
                                   DIVIDEND : '0;
                end
            end
            ST_MULT:
                div_reg <= period_reg * mult;
            ST_DIV:
            begin
                rem_reg <= fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_DONE:
                ;
            default:
                ;
        endcase
    end

    // Last valid rpm: update on a captured (not timeout) reading within the limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_rpm_reg <= '0;
        else if (state_reg == ST_DONE && out_free && !timeout_reg && !glitch)
            last_rpm_reg <= quo_reg[RPM_W-1:0];
    end

    // Output register: hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_rpm_reg    <= glitch ? last_rpm_reg : quo_reg[RPM_W-1:0];
            out_glitch_reg <= glitch;
        end
    end

endmodule

// File: tb/tb_tacho_period_to_rpm.sv
// Testbench for tacho_period_to_rpm: drives tachometer capture beats, predicts
// each rpm beat in a local model and checks the output stream field by field.
// Depends on tpr_pkg and the tacho_period_to_rpm RTL.
module tb_tacho_period_to_rpm
    import tpr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic             glitch;
    } rpm_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PERIOD_W-1:0]   s_tdata = '0;   // [31:0] period_us
    logic [1:0]            s_tuser = STATUS_CAPTURED;   // [1:0] capture_status
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [RPM_W-1:0]      m_tdata;        // [15:0] rpm
    logic                  m_tuser;        // [0] glitch_held
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PULSE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Local copy of the converter state and registers
    logic [PPR_W-1:0] model_ppr = 4'd2;
    logic [RPM_W-1:0] model_max = 16'd20000;
    logic [RPM_W-1:0] held_rpm = '0;

    rpm_beat_t   expected_rpm_q[$];
    int unsigned fail_cnt = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned glitches_seen = 0;
    int unsigned stall_left = 0;
    bit          tx_fast = 1'b0;
    bit          rx_fast = 1'b0;

    tacho_period_to_rpm #(
        .PERIOD_WIDTH(32)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bound the run in case the block hangs
    initial
    begin
        #20_000_000;
        $display("tb_tacho_period_to_rpm: FAIL");
        $finish;
    end

    // Count a failure; print only the first few
    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Work out the beat a capture produces and advance the held rpm
    function automatic bit predict_capture(input capture_status_t st,
                                           input logic [PERIOD_W-1:0] per,
                                           output rpm_beat_t res);
        logic [63:0] mult;
        logic [63:0] raw;
        res = '{rpm: '0, glitch: 1'b0};
        case (st)
            STATUS_TIMEOUT:
            begin
                return 1'b1;
            end
            STATUS_CAPTURED:
            begin
                // A zero pulse count acts as one pulse per revolution
                mult = (model_ppr == 0) ? 64'd1 : 64'(model_ppr);
                if (per == 0 || per > USEC_PER_MIN)
                begin
                    raw = 64'd0;
                end
                else
                begin
                    raw = 64'(USEC_PER_MIN) / (64'(per) * mult);
                end
                if (raw > 64'(model_max))
                begin
                    res.rpm = held_rpm;
                    res.glitch = 1'b1;
                end
                else
                begin
                    held_rpm = raw[RPM_W-1:0];
                    res.rpm = raw[RPM_W-1:0];
                end
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    // Send one capture beat after a random gap; keep tvalid high on a zero gap
    task automatic send_capture(input capture_status_t st, input logic [PERIOD_W-1:0] per);
        int unsigned gap;
        rpm_beat_t   res;
        gap = tx_fast ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= per;
        s_tuser <= st;
        do @(posedge clk); while (!s_tready);
        if (predict_capture(st, per, res))
        begin
            expected_rpm_q.push_back(res);
        end
        items_sent++;
    endtask

    // Hold off until every expected beat is out, then let a failed capture settle
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_rpm_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write both registers back to back; only called while the block is idle
    task automatic set_config(input logic [CFG_DATA_W-1:0] ppr_word,
                              input logic [CFG_DATA_W-1:0] max_word);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PULSE_COUNT;
        cfg_data <= ppr_word;
        @(posedge clk);
        cfg_index <= CFG_MAX_RPM;
        cfg_data <= max_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_ppr = ppr_word[PPR_W-1:0];
        model_max = max_word;
    endtask

    // Check each rpm beat against the oldest prediction and draw the next stall
    always @(posedge clk)
    begin : rpm_sink
        rpm_beat_t want;
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser)
            begin
                glitches_seen++;
            end
            if (expected_rpm_q.size() == 0)
            begin
                note_failure($sformatf("unexpected beat: rpm %0d glitch %0d", m_tdata, m_tuser));
            end
            else
            begin
                want = expected_rpm_q.pop_front();
                if (m_tdata !== want.rpm)
                begin
                    note_failure($sformatf("rpm mismatch: expected %0d got %0d",
                                           want.rpm, m_tdata));
                end
                if (m_tuser !== want.glitch)
                begin
                    note_failure($sformatf("glitch_held mismatch: expected %0d got %0d",
                                           want.glitch, m_tuser));
                end
            end
            stall_left = rx_fast ? 0 : $urandom_range(0, 13);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        m_tready <= (stall_left == 0);
    end

    // Reset settings: limit boundary, zero and long periods, every status
    task automatic test_default_limits();
        send_capture(STATUS_CAPTURED, 32'd0);
        send_capture(STATUS_CAPTURED, 32'd1);
        send_capture(STATUS_CAPTURED, 32'd1500);
        send_capture(STATUS_CAPTURED, 32'd1501);
        send_capture(STATUS_CAPTURED, 32'd3000);
        send_capture(STATUS_CAPTURED, 32'd1);
        send_capture(STATUS_CAPTURED, 32'd60000000);
        send_capture(STATUS_CAPTURED, 32'd60000001);
        send_capture(STATUS_CAPTURED, 32'hFFFF_FFFF);
        send_capture(STATUS_TIMEOUT, 32'hDEAD_BEEF);
        send_capture(STATUS_FAILED, 32'd3000);
        send_capture(STATUS_RSVD, 32'd3000);
        send_capture(STATUS_CAPTURED, 32'd12345);
        wait_results_drained();
    endtask

    // Register extremes: zero pulse count, zero and full-scale limits
    task automatic test_register_extremes();
        set_config(16'hFFF0, 16'd0);
        send_capture(STATUS_CAPTURED, 32'd1);
        send_capture(STATUS_CAPTURED, 32'd0);
        send_capture(STATUS_TIMEOUT, 32'h5555_AAAA);
        wait_results_drained();
        set_config(16'd15, 16'hFFFF);
        send_capture(STATUS_CAPTURED, 32'd58);
        send_capture(STATUS_CAPTURED, 32'd62);
        wait_results_drained();
        set_config(16'hA5F1, 16'd1);
        send_capture(STATUS_CAPTURED, 32'd60000000);
        send_capture(STATUS_CAPTURED, 32'd30000000);
        wait_results_drained();
        set_config(16'd1, 16'hFFFF);
        send_capture(STATUS_CAPTURED, 32'd916);
        send_capture(STATUS_CAPTURED, 32'd915);
        wait_results_drained();
    endtask

    // Random captures over several register settings and idle patterns
    task automatic test_random_traffic();
        int unsigned       pick;
        logic [63:0]       thr;
        logic [PERIOD_W-1:0] per;
        capture_status_t   st;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_config(16'd1, 16'hFFFF);
                1: set_config(16'd8, 16'd1);
                2: set_config({12'($urandom), 4'd0}, 16'd0);
                3: set_config(16'd15, 16'd20000);
                default: set_config(16'($urandom), 16'($urandom));
            endcase
            tx_fast = (phase % 3 == 1);
            rx_fast = (phase % 4 == 2) || (phase == 7);
            // Period near the glitch boundary for this setting
            thr = 64'(USEC_PER_MIN) /
                  (((model_ppr == 0) ? 64'd1 : 64'(model_ppr)) * (64'(model_max) + 64'd1));
            for (int i = 0; i < 200; i++)
            begin
                if (phase == 4 && i == 100)
                begin
                    wait_results_drained();
                end
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    st = STATUS_CAPTURED;
                end
                else if (pick < 85)
                begin
                    st = STATUS_TIMEOUT;
                end
                else if (pick < 95)
                begin
                    st = STATUS_FAILED;
                end
                else
                begin
                    st = STATUS_RSVD;
                end
                case ($urandom_range(0, 9))
                    0: per = '0;
                    1, 2: per = $urandom;
                    3, 4: per = $urandom_range(1, 5000);
                    5, 6, 7:
                    begin
                        if (thr > 3)
                            per = 32'(thr - 3 + $urandom_range(0, 6));
                        else
                            per = $urandom_range(1, 6);
                    end
                    8: per = USEC_PER_MIN - 4 + $urandom_range(0, 8);
                    default: per = $urandom_range(5000, 200000);
                endcase
                send_capture(st, per);
            end
            wait_results_drained();
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_limits();
        test_register_extremes();
        test_random_traffic();

        wait_results_drained();
        foreach (expected_rpm_q[k])
        begin
            note_failure($sformatf("missing beat: rpm %0d glitch %0d",
                                   expected_rpm_q[k].rpm, expected_rpm_q[k].glitch));
        end

        $display("Covered %0d captures over reset, extreme and random register settings,",
                 items_sent);
        $display("giving %0d rpm beats of which %0d held a glitch; %0d failures counted.",
                 results_seen, glitches_seen, fail_cnt);
        if (fail_cnt == 0)
        begin
            $display("tb_tacho_period_to_rpm: PASS");
        end
        else
        begin
            $display("tb_tacho_period_to_rpm: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/tpr_pkg.sv
rtl/tacho_period_to_rpm.sv
tb/tb_tacho_period_to_rpm.sv
